// ===== src/mie_pkg.sv =====
// Package with shared types and constants for the modular inverse block.
`timescale 1ns / 1ps

package mie_pkg;

    // Widths of the stream fields.
    localparam int VALUE_W        = 63;
    localparam int IN_TDATA_W     = 128;
    localparam int OUT_TDATA_W    = 64;
    localparam int WORD_BITS_DEF  = 64;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_ALIGN = 7'b0000100,
        ST_SUB   = 7'b0001000,
        ST_SWAP  = 7'b0010000,
        ST_FIX   = 7'b0100000,
        ST_SIGN  = 7'b1000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift_up;
        logic sub_step;
        logic swap;
        logic fix;
        logic sign;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rem_zero;
        logic can_shift;
        logic k_zero;
    } t_status;

endpackage

// ===== src/mie_datapath.sv =====
// Datapath of the modular inverse: remainder and coefficient registers with shift-subtract division.
`timescale 1ns / 1ps

module mie_datapath
    import mie_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  t_cmd                 i_cmd,
    input  logic [VALUE_W-1:0]   i_value,
    input  logic [VALUE_W-1:0]   i_modulus,
    output t_status              o_status,
    output logic [VALUE_W-1:0]   o_inverse,
    output logic                 o_fail
);

    localparam int OW = WORD_BITS - 1;
    localparam int KW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] r_rp, r_rc, r_tp, r_tc, r_d, r_e, r_m;
    logic [KW-1:0]        r_k;
    logic                 r_neg;
    logic                 r_mzero;
    logic [OW-1:0]        r_res_inv;
    logic                 r_res_fail;

    logic [WORD_BITS-1:0] w_v, w_m, w_d_up;
    logic                 w_fail;

    assign w_v    = WORD_BITS'(i_value[OW-1:0]);
    assign w_m    = WORD_BITS'(i_modulus[OW-1:0]);
    // The divisor never exceeds 63 bits, so its top bit is clear.
    assign w_d_up = {r_d[WORD_BITS-2:0], 1'b0};
    assign w_fail = r_mzero | (r_rp != WORD_BITS'(1));

    assign o_status.rem_zero  = (r_rc == '0);
    assign o_status.can_shift = (w_d_up <= r_rp);
    assign o_status.k_zero    = (r_k == '0);
    assign o_inverse          = VALUE_W'(r_res_inv);
    assign o_fail             = r_res_fail;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // One extra Euclid step from (value, modulus) reduces the value first.
            r_rp    <= w_v;
            r_rc    <= w_m;
            r_tp    <= WORD_BITS'(1);
            r_tc    <= '0;
            r_d     <= w_m;
            r_e     <= '0;
            r_k     <= '0;
            r_neg   <= 1'b1;
            r_m     <= w_m;
            r_mzero <= (w_m == '0);
        end else if (i_cmd.shift_up) begin
            r_d <= w_d_up;
            r_e <= {r_e[WORD_BITS-2:0], 1'b0};
            r_k <= r_k + KW'(1);
        end else if (i_cmd.sub_step) begin
            if (r_d <= r_rp) begin
                r_rp <= r_rp - r_d;
                r_tp <= r_tp + r_e;
            end
            if (r_k != '0) begin
                r_d <= r_d >> 1;
                r_e <= r_e >> 1;
                r_k <= r_k - KW'(1);
            end
        end else if (i_cmd.swap) begin
            r_rp  <= r_rc;
            r_rc  <= r_rp;
            r_tp  <= r_tc;
            r_tc  <= r_tp;
            r_d   <= r_rp;
            r_e   <= r_tp;
            r_k   <= '0;
            r_neg <= ~r_neg;
        end else if (i_cmd.fix) begin
            if (!r_mzero && (r_tp >= r_m)) begin
                r_tp <= r_tp - r_m;
            end
        end else if (i_cmd.sign) begin
            r_res_fail <= w_fail;
            if (w_fail) begin
                r_res_inv <= '0;
            end else if (!r_neg && (r_tp != '0)) begin
                // The gcd coefficient carries the sign opposite to the current one.
                r_res_inv <= OW'(r_m - r_tp);
            end else begin
                r_res_inv <= OW'(r_tp);
            end
        end
    end

endmodule

// ===== src/mie_ctrl.sv =====
// Controller state machine that sequences the Euclid steps of the modular inverse.
`timescale 1ns / 1ps

module mie_ctrl
    import mie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_out_free,
    input  t_status i_status,
    output logic    o_idle,
    output logic    o_push,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_done, n_done;

    assign o_idle = (r_state == ST_IDLE) && !r_done;
    assign o_push = r_done && i_out_free;

    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        o_cmd   = '0;
        if (o_push) begin
            n_done = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_status.rem_zero ? ST_FIX : ST_ALIGN;
            end
            ST_ALIGN: begin
                if (i_status.can_shift) begin
                    o_cmd.shift_up = 1'b1;
                end else begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                o_cmd.sub_step = 1'b1;
                if (i_status.k_zero) begin
                    n_state = ST_SWAP;
                end
            end
            ST_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state    = ST_CHECK;
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_SIGN;
            end
            ST_SIGN: begin
                o_cmd.sign = 1'b1;
                n_done     = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

endmodule

// ===== src/modular_inverse_egcd.sv =====
// Top level of the modular inverse block: stream ports, output register, controller and datapath.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: value [62:0], modulus [125:63], zero pad [127:126]
//  m_axis    out        tdata: inverse [62:0], zero pad [63]; tuser: status [0]
//
//  Each request runs the extended Euclidean algorithm, whose first step divides the
//  value by the modulus. Every quotient is found by shift-subtract long division: a
//  step checks the remainder, shifts the divisor up into alignment, subtracts it back
//  down one quotient bit at a time and then swaps the two remainders and coefficients.
//  A request is first accepted, and the run closes with a last check, a fix and a sign step.
//  Reset is synchronous and active low and clears only control state.
//  A finished result waits in the output register; the next request is taken while
//  it waits, and a second result is held in the datapath until the register frees.
//
module modular_inverse_egcd
    import mie_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Request stream: value (bits 62:0), modulus (bits 125:63), zero pad.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result stream: inverse (bits 62:0), zero pad.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Result flag: status (bit 0), set when the gcd is not one or the modulus is zero.
    output logic                   o_m_axis_tuser
);

    t_cmd                w_cmd;
    t_status             w_status;
    logic                w_idle;
    logic                w_push;
    logic                w_start;
    logic                w_out_free;
    logic [VALUE_W-1:0]  w_inverse;
    logic                w_fail;

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_inverse;
    logic                r_out_status;

    // The controller only takes a request with no result pending in the datapath.
    assign o_s_axis_tready = w_idle;
    assign w_start         = i_s_axis_tvalid && w_idle;

    // The output register is free when empty or when its result leaves this cycle.
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    mie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_idle     (w_idle),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    mie_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_value   (i_s_axis_tdata[VALUE_W-1:0]),
        .i_modulus (i_s_axis_tdata[2*VALUE_W-1:VALUE_W]),
        .o_status  (w_status),
        .o_inverse (w_inverse),
        .o_fail    (w_fail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_inverse <= w_inverse;
            r_out_status  <= w_fail;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_inverse);
    assign o_m_axis_tuser  = r_out_status;

endmodule
